/* rtl/golomb_signed_bit_decoder_macros.svh */
// ----------------------------------------------------------------------------
// Golomb signed bit decoder assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef GOLOMB_SIGNED_BIT_DECODER_MACROS_SVH
`define GOLOMB_SIGNED_BIT_DECODER_MACROS_SVH

`ifndef SYNTHESIS
`define GSBD_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define GSBD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define GSBD_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define GSBD_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

/* rtl/gsbd_pkg.sv */
// ----------------------------------------------------------------------------
// Golomb signed bit decoder package
// Shared types, register map and status codes.
// ----------------------------------------------------------------------------
package gsbd_pkg;

  localparam int DIV_W    = 16;
  localparam int K_W      = 5;
  localparam int LEFT_W   = 4;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  // register index, taken from paddr[2]
  localparam logic REG_DIVISOR   = 1'b0;
  localparam logic REG_SIGN_MODE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_INCOMPLETE = 2'd1,
    ST_OVERFLOW   = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    PH_PREFIX = 4'b0001,
    PH_REM    = 4'b0010,
    PH_EXT    = 4'b0100,
    PH_SIGN   = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [DIV_W-1:0] m;       // effective divisor, never zero
    logic [K_W-1:0]   k;       // ceil(log2 m)
    logic [DIV_W-1:0] u;       // 2^k - m
    logic             zigzag;
    logic             clear;   // register write this cycle
  } cfg_t;

endpackage

/* rtl/gsbd_cfg.sv */
// ----------------------------------------------------------------------------
// Golomb decoder register block
// APB register file; derives the truncated-binary constants on each divisor write.
// ----------------------------------------------------------------------------
module gsbd_cfg #(
  parameter int DIVISOR_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [gsbd_pkg::PADDR_W-1:0] paddr,
  input  logic [gsbd_pkg::PDATA_W-1:0] pwdata,
  output logic [gsbd_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  output gsbd_pkg::cfg_t               cfg
);
  import gsbd_pkg::*;

  logic [DIV_W-1:0] divisor;
  logic             sign_mode;
  logic [DIV_W-1:0] m;
  logic [K_W-1:0]   k;
  logic [DIV_W-1:0] u;
  logic             wr;
  logic             reg_idx;

  logic [DIV_W-1:0] dv_masked;
  logic [DIV_W-1:0] m_new;
  logic [DIV_W-1:0] m_dec;
  logic [K_W-1:0]   k_new;
  logic [DIV_W:0]   pow_k;
  logic [DIV_W:0]   u_wide;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign wr      = psel && penable && pwrite;

  always_comb begin
    for (int i = 0; i < DIV_W; i++) begin
      dv_masked[i] = (i < DIVISOR_BITS) ? pwdata[i] : 1'b0;
    end
    m_new = (dv_masked == '0) ? DIV_W'(1) : dv_masked;
    m_dec = m_new - DIV_W'(1);
    k_new = '0;
    for (int i = 0; i < DIV_W; i++) begin
      if (m_dec[i]) begin
        k_new = K_W'(i + 1);
      end
    end
    pow_k  = (DIV_W+1)'(1) << k_new;
    u_wide = pow_k - {1'b0, m_new};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      divisor   <= DIV_W'(1);
      sign_mode <= 1'b0;
      m         <= DIV_W'(1);
      k         <= '0;
      u         <= '0;
    end else if (wr) begin
      unique case (reg_idx)
        REG_DIVISOR: begin
          divisor <= pwdata[DIV_W-1:0];
          m       <= m_new;
          k       <= k_new;
          u       <= u_wide[DIV_W-1:0];
        end
        REG_SIGN_MODE: begin
          sign_mode <= pwdata[0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_DIVISOR:   prdata = PDATA_W'(divisor);
      REG_SIGN_MODE: prdata = PDATA_W'(sign_mode);
      default:       prdata = '0;
    endcase
  end

  assign cfg.m      = m;
  assign cfg.k      = k;
  assign cfg.u      = u;
  assign cfg.zigzag = sign_mode;
  assign cfg.clear  = wr;

endmodule

/* rtl/gsbd_core.sv */
// ----------------------------------------------------------------------------
// Golomb decoder bit engine
// Per-bit codeword state update and registered result beat.
// ----------------------------------------------------------------------------
`include "golomb_signed_bit_decoder_macros.svh"

module gsbd_core #(
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  gsbd_pkg::cfg_t        cfg,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic                  code_bit,
  input  logic                  stream_end,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [VALUE_BITS-1:0] value,
  output logic [1:0]            status
);
  import gsbd_pkg::*;

  localparam int SUM_W = ((VALUE_BITS > DIV_W + 1) ? VALUE_BITS : DIV_W + 1) + 1;

  phase_t                phase, phase_next;
  logic [VALUE_BITS-1:0] mag_sum, mag_sum_next;
  logic [DIV_W-1:0]      rem_bits, rem_bits_next;
  logic [LEFT_W-1:0]     bits_left, bits_left_next;
  logic                  overflowed, overflowed_next;

  logic                  in_acc;
  logic                  do_fin;
  logic                  do_emit;
  logic                  go_idle;
  logic [VALUE_BITS-1:0] emit_val;
  status_t               emit_st;

  logic [SUM_W-1:0]      sum_p;
  logic                  ovf_p;
  logic [DIV_W-1:0]      rem_sh;
  logic [DIV_W-1:0]      rem_cand;
  logic                  short_ok;
  logic [DIV_W:0]        ext_r;
  logic [DIV_W:0]        fin_r;
  logic [SUM_W-1:0]      sum_f;
  logic                  ovf_f;
  logic [VALUE_BITS-1:0] mag_f;
  logic [LEFT_W-1:0]     left_dec;
  logic                  open_cw;

  assign in_acc   = s_tvalid && s_tready;
  assign s_tready = !m_tvalid || m_tready;

  always_comb begin
    sum_p    = SUM_W'(mag_sum) + SUM_W'(cfg.m);
    ovf_p    = (sum_p >> VALUE_BITS) != '0;
    rem_sh   = {rem_bits[DIV_W-2:0], code_bit};
    rem_cand = (phase == PH_REM) ? rem_sh : '0;
    short_ok = rem_cand < cfg.u;
    ext_r    = {rem_bits, code_bit} - {1'b0, cfg.u};
    fin_r    = (phase == PH_EXT) ? ext_r : {1'b0, rem_cand};
    sum_f    = SUM_W'(mag_sum) + SUM_W'(fin_r);
    ovf_f    = overflowed || ((sum_f >> VALUE_BITS) != '0);
    mag_f    = overflowed ? mag_sum : sum_f[VALUE_BITS-1:0];
    left_dec = bits_left - LEFT_W'(1);
    open_cw  = (phase != PH_PREFIX) || (mag_sum != '0) || overflowed;
  end

  always_comb begin
    phase_next      = phase;
    mag_sum_next    = mag_sum;
    rem_bits_next   = rem_bits;
    bits_left_next  = bits_left;
    overflowed_next = overflowed;
    do_fin          = 1'b0;
    do_emit         = 1'b0;
    go_idle         = 1'b0;
    emit_val        = '0;
    emit_st         = ST_OK;

    if (cfg.clear) begin
      go_idle = 1'b1;
    end else if (in_acc) begin
      if (stream_end) begin
        go_idle = 1'b1;
        if (open_cw) begin
          do_emit = 1'b1;
          emit_st = ST_INCOMPLETE;
        end
      end else begin
        unique case (phase)
          PH_PREFIX: begin
            if (!code_bit) begin
              if (!overflowed) begin
                if (ovf_p) begin
                  overflowed_next = 1'b1;
                end else begin
                  mag_sum_next = sum_p[VALUE_BITS-1:0];
                end
              end
            end else begin
              rem_bits_next = '0;
              if (cfg.k == '0) begin
                do_fin = 1'b1;
              end else if (cfg.k == K_W'(1)) begin
                if (short_ok) begin
                  do_fin = 1'b1;
                end else begin
                  phase_next = PH_EXT;
                end
              end else begin
                bits_left_next = LEFT_W'(cfg.k - K_W'(1));
                phase_next     = PH_REM;
              end
            end
          end
          PH_REM: begin
            rem_bits_next  = rem_sh;
            bits_left_next = left_dec;
            if (left_dec == '0) begin
              if (short_ok) begin
                do_fin = 1'b1;
              end else begin
                phase_next = PH_EXT;
              end
            end
          end
          PH_EXT: begin
            do_fin = 1'b1;
          end
          PH_SIGN: begin
            do_emit = 1'b1;
            if (overflowed) begin
              emit_st = ST_OVERFLOW;
            end else if (code_bit) begin
              if (mag_sum[VALUE_BITS-1] && (mag_sum[VALUE_BITS-2:0] != '0)) begin
                emit_st = ST_OVERFLOW;
              end else begin
                emit_val = '0 - mag_sum;
              end
            end else if (mag_sum[VALUE_BITS-1]) begin
              emit_st = ST_OVERFLOW;
            end else begin
              emit_val = mag_sum;
            end
          end
          default: begin
            go_idle = 1'b1;
          end
        endcase

        if (do_fin) begin
          if (cfg.zigzag) begin
            do_emit = 1'b1;
            if (ovf_f) begin
              emit_st = ST_OVERFLOW;
            end else begin
              emit_val = mag_f[0] ? ~(mag_f >> 1) : (mag_f >> 1);
            end
          end else if (!ovf_f && (mag_f == '0)) begin
            do_emit = 1'b1;
          end else begin
            phase_next      = PH_SIGN;
            mag_sum_next    = mag_f;
            overflowed_next = ovf_f;
          end
        end
        if (do_emit) begin
          go_idle = 1'b1;
        end
      end
    end

    if (go_idle) begin
      phase_next      = PH_PREFIX;
      mag_sum_next    = '0;
      rem_bits_next   = '0;
      bits_left_next  = '0;
      overflowed_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_PREFIX;
      mag_sum    <= '0;
      rem_bits   <= '0;
      bits_left  <= '0;
      overflowed <= 1'b0;
    end else begin
      phase      <= phase_next;
      mag_sum    <= mag_sum_next;
      rem_bits   <= rem_bits_next;
      bits_left  <= bits_left_next;
      overflowed <= overflowed_next;
    end
  end

  // result beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (do_emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_emit) begin
      value  <= emit_val;
      status <= emit_st;
    end
  end

  `GSBD_ASSERT_IMPL(a_bad_status_zero, clk, rst, m_tvalid && (status != ST_OK), value == '0, "non-ok result with nonzero value")
  `GSBD_ASSERT_NEXT(a_clear_idles, clk, rst, cfg.clear, (phase == PH_PREFIX) && (mag_sum == '0) && !overflowed, "register write did not drop codeword")
  `GSBD_ASSERT_NEXT(a_end_idles, clk, rst, in_acc && stream_end, (phase == PH_PREFIX) && (mag_sum == '0) && !overflowed, "stream end left codeword open")
  `GSBD_ASSERT_NEXT(a_ovf_holds, clk, rst, overflowed && in_acc && !stream_end && !code_bit && !cfg.clear && (phase == PH_PREFIX), $stable(mag_sum) && overflowed, "accumulator moved after overflow")

endmodule

/* rtl/golomb_signed_bit_decoder.sv */
// A result beat is registered as the code bit that ends its codeword is accepted.
// Throughput: one code bit per cycle while s_tready is high; one add/compare in gsbd_core.
// Stream ends and register writes need no recovery time.
// Reset (rst, synchronous, active high): divisor 1, sign_mode 0, decoder in prefix phase.
// ----------------------------------------------------------------------------
// Golomb signed bit decoder
// Serial Golomb/truncated-binary decoder with sign-bit or zigzag mapping.
// ----------------------------------------------------------------------------
module golomb_signed_bit_decoder #(
  parameter int VALUE_BITS   = 32,
  parameter int DIVISOR_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [gsbd_pkg::PADDR_W-1:0]          paddr,
  input  logic [gsbd_pkg::PDATA_W-1:0]          pwdata,
  output logic [gsbd_pkg::PDATA_W-1:0]          prdata,
  output logic                                  pready,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [7:0]                            s_tdata,  // [0] code_bit
  input  logic                                  s_tlast,  // stream_end
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [((VALUE_BITS + 7) / 8) * 8-1:0] m_tdata,  // value
  output logic [1:0]                            m_tuser   // status
);
  import gsbd_pkg::*;

  localparam int TDATA_W = ((VALUE_BITS + 7) / 8) * 8;

  cfg_t                  cfg;
  logic [VALUE_BITS-1:0] value;

  gsbd_cfg #(
    .DIVISOR_BITS (DIVISOR_BITS)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gsbd_core #(
    .VALUE_BITS (VALUE_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .code_bit   (s_tdata[0]),
    .stream_end (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .value      (value),
    .status     (m_tuser)
  );

  assign m_tdata = TDATA_W'(value);

endmodule
